// ----- rtl/core/sacl_pkg.sv -----
`default_nettype none

package sacl_pkg;

    // Field widths fixed by the result format
    localparam int TAG_W      = 16;
    localparam int AGE_W      = 4;
    localparam int OFF_W      = 8;
    localparam int BLK_W      = 16;
    localparam int SET_OUT_W  = 4;
    localparam int WAY_OUT_W  = 4;
    localparam int ADDR_IN_W  = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    localparam logic [AGE_W-1:0] AGE_MAX        = 4'd15;
    localparam logic [3:0]       BLOCK_LOG2_MAX = 4'd8;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LOG2 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SETS_LOG2  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MEM_LOG2   = 2'd2;

    // Configuration register reset values
    localparam logic [3:0] RST_BLOCK_LOG2 = 4'd2;
    localparam logic [2:0] RST_SETS_LOG2  = 3'd2;
    localparam logic [4:0] RST_MEM_LOG2   = 5'd16;

    typedef struct packed {
        logic [3:0] block_bytes_log2;
        logic [2:0] sets_log2;
        logic [4:0] memory_bytes_log2;
    } t_cfg;

    // Classified item passed from front to back
    typedef struct packed {
        logic                 oor;
        logic [TAG_W-1:0]     tag;
        logic [OFF_W-1:0]     off;
        logic [BLK_W-1:0]     blk;
        logic [SET_OUT_W-1:0] set_out;
    } t_job;

    typedef struct packed {
        logic                 status;
        logic                 hit;
        logic [SET_OUT_W-1:0] set_index;
        logic [WAY_OUT_W-1:0] way;
        logic [TAG_W-1:0]     line_tag;
        logic [OFF_W-1:0]     byte_offset;
        logic [BLK_W-1:0]     fill_block;
        logic                 evicted;
    } t_result;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE,
        ST_DONE
    } t_back_state;

endpackage

`default_nettype wire

// ----- rtl/core/sacl_fifo.sv -----
`default_nettype none

module sacl_fifo #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 2
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire logic [DATA_W-1:0] i_data,
    output logic                   o_full,
    input  wire logic              i_pop,
    output logic [DATA_W-1:0]      o_data,
    output logic                   o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Store the item
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/sacl_front.sv -----
`default_nettype none

module sacl_front #(
    parameter int TOTAL_LINES  = 16,
    parameter int ADDRESS_BITS = 16
) (
    input  wire sacl_pkg::t_cfg                        i_cfg,
    input  wire logic                                  i_push,
    input  wire logic [sacl_pkg::ADDR_IN_W-1:0]        i_address,
    output logic                                       o_full,
    output logic                                       o_job_push,
    output logic [$bits(sacl_pkg::t_job)+$clog2(TOTAL_LINES)+$clog2(TOTAL_LINES+1)-1:0]
                                                       o_job_data,
    input  wire logic                                  i_job_full
);

    localparam int LINE_W = $clog2(TOTAL_LINES);
    localparam int CNT_W  = $clog2(TOTAL_LINES + 1);
    localparam int S_MAX  = $clog2(TOTAL_LINES + 1) - 1;
    localparam logic [sacl_pkg::ADDR_IN_W-1:0] ADDR_MASK =
        (ADDRESS_BITS >= sacl_pkg::ADDR_IN_W) ? '1 :
        sacl_pkg::ADDR_IN_W'((32'd1 << ADDRESS_BITS) - 32'd1);

    logic [sacl_pkg::ADDR_IN_W-1:0] addr;
    logic [3:0]                     blk_shift;
    logic [2:0]                     set_shift;
    logic [sacl_pkg::BLK_W-1:0]     blk;
    logic [LINE_W-1:0]              set_sel;
    logic [CNT_W-1:0]               ways;
    logic [LINE_W-1:0]              base;
    sacl_pkg::t_job                 job;

    // Clamp the geometry to what the line store holds
    always_comb begin
        addr      = i_address & ADDR_MASK;
        blk_shift = (i_cfg.block_bytes_log2 > sacl_pkg::BLOCK_LOG2_MAX) ?
                    sacl_pkg::BLOCK_LOG2_MAX : i_cfg.block_bytes_log2;
        set_shift = (32'(i_cfg.sets_log2) > S_MAX) ? 3'(S_MAX) : i_cfg.sets_log2;
    end

    // Split the address into offset, set and tag, and flag out-of-range addresses
    always_comb begin
        blk     = addr >> blk_shift;
        set_sel = LINE_W'(blk & ~(16'hFFFF << set_shift));
        ways    = CNT_W'(TOTAL_LINES >> set_shift);
        base    = LINE_W'(CNT_W'(set_sel) * ways);

        job.oor     = ((addr >> i_cfg.memory_bytes_log2) != '0);
        job.tag     = blk >> set_shift;
        job.off     = sacl_pkg::OFF_W'(addr & ~(16'hFFFF << blk_shift));
        job.blk     = blk;
        job.set_out = sacl_pkg::SET_OUT_W'(set_sel);
    end

    assign o_job_data = {job, base, ways};
    assign o_job_push = i_push && !i_job_full;
    assign o_full     = i_job_full;

endmodule

`default_nettype wire

// ----- rtl/core/sacl_back.sv -----
`default_nettype none

module sacl_back #(
    parameter int TOTAL_LINES = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [$bits(sacl_pkg::t_job)+$clog2(TOTAL_LINES)+$clog2(TOTAL_LINES+1)-1:0]
                                   i_job_data,
    input  wire logic              i_job_empty,
    output logic                   o_job_pop,
    output logic                   o_res_push,
    output sacl_pkg::t_result      o_res_data,
    input  wire logic              i_res_full
);

    localparam int LINE_W = $clog2(TOTAL_LINES);
    localparam int CNT_W  = $clog2(TOTAL_LINES + 1);
    localparam int WORD_W = sacl_pkg::TAG_W + sacl_pkg::AGE_W;

    // Incoming item
    sacl_pkg::t_job     in_job;
    logic [LINE_W-1:0]  in_base;
    logic [CNT_W-1:0]   in_ways;

    // Control
    sacl_pkg::t_back_state r_state;
    sacl_pkg::t_back_state n_state;
    logic                  r_cmp_vld;
    logic [TOTAL_LINES-1:0] r_valid;

    // Item context and scan results
    sacl_pkg::t_job            r_job;
    logic [LINE_W-1:0]         r_base;
    logic [CNT_W-1:0]          r_ways;
    logic [CNT_W-1:0]          r_idx;
    logic [LINE_W-1:0]         r_cmp_idx;
    logic                      r_hit;
    logic [LINE_W-1:0]         r_hit_way;
    logic [sacl_pkg::AGE_W-1:0] r_hit_age;
    logic                      r_inv_found;
    logic [LINE_W-1:0]         r_inv_way;
    logic [LINE_W-1:0]         r_vic_way;
    logic [sacl_pkg::AGE_W-1:0] r_vic_age;

    // Tag and age store, one word per line
    logic [WORD_W-1:0] r_mem [TOTAL_LINES];
    logic [WORD_W-1:0] r_rdata;

    logic                       issue;
    logic [LINE_W-1:0]          line_rd;
    logic [LINE_W-1:0]          line_cmp;
    logic                       cmp_valid;
    logic [sacl_pkg::TAG_W-1:0] cmp_tag;
    logic [sacl_pkg::AGE_W-1:0] cmp_age;
    logic [LINE_W-1:0]          sel_way;
    logic [sacl_pkg::AGE_W:0]   age_limit;
    logic                       rd_en;
    logic                       wr_en;
    logic [WORD_W-1:0]          wr_data;
    logic                       set_valid;

    assign {in_job, in_base, in_ways} = i_job_data;

    // Decode the way under compare and the final choice
    always_comb begin
        issue     = (r_idx != r_ways);
        line_rd   = r_base + r_idx[LINE_W-1:0];
        line_cmp  = r_base + r_cmp_idx;
        cmp_valid = r_valid[line_cmp];
        cmp_tag   = r_rdata[WORD_W-1:sacl_pkg::AGE_W];
        cmp_age   = r_rdata[sacl_pkg::AGE_W-1:0];
        sel_way   = r_hit ? r_hit_way : (r_inv_found ? r_inv_way : r_vic_way);
        age_limit = r_hit ? {1'b0, r_hit_age} : {1'b1, {sacl_pkg::AGE_W{1'b0}}};
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            sacl_pkg::ST_IDLE: begin
                if (!i_job_empty) begin
                    n_state = in_job.oor ? sacl_pkg::ST_DONE : sacl_pkg::ST_SCAN;
                end
            end
            sacl_pkg::ST_SCAN: begin
                if (!issue) begin
                    n_state = sacl_pkg::ST_UPDATE;
                end
            end
            sacl_pkg::ST_UPDATE: begin
                if (!issue) begin
                    n_state = sacl_pkg::ST_DONE;
                end
            end
            sacl_pkg::ST_DONE: begin
                if (!i_res_full) begin
                    n_state = sacl_pkg::ST_IDLE;
                end
            end
            default: n_state = sacl_pkg::ST_IDLE;
        endcase
    end

    // State outputs: queue handshakes, store reads and write-backs
    always_comb begin
        o_job_pop  = 1'b0;
        o_res_push = 1'b0;
        rd_en      = 1'b0;
        wr_en      = 1'b0;
        wr_data    = r_rdata;
        set_valid  = 1'b0;
        case (r_state)
            sacl_pkg::ST_IDLE: begin
                o_job_pop = !i_job_empty;
            end
            sacl_pkg::ST_SCAN: begin
                rd_en = issue;
            end
            sacl_pkg::ST_UPDATE: begin
                rd_en = issue;
                if (r_cmp_vld) begin
                    if (r_cmp_idx == sel_way) begin
                        wr_en     = 1'b1;
                        set_valid = 1'b1;
                        wr_data   = {(r_hit ? cmp_tag : r_job.tag), {sacl_pkg::AGE_W{1'b0}}};
                    end else if (cmp_valid && ({1'b0, cmp_age} < age_limit) &&
                                 (cmp_age != sacl_pkg::AGE_MAX)) begin
                        wr_en   = 1'b1;
                        wr_data = {cmp_tag, cmp_age + 1'b1};
                    end
                end
            end
            sacl_pkg::ST_DONE: begin
                o_res_push = !i_res_full;
            end
            default: begin
                o_job_pop = 1'b0;
            end
        endcase
    end

    // Assemble the result
    always_comb begin
        o_res_data = '0;
        if (r_job.oor) begin
            o_res_data.status = 1'b1;
        end else begin
            o_res_data.hit         = r_hit;
            o_res_data.set_index   = r_job.set_out;
            o_res_data.way         = sacl_pkg::WAY_OUT_W'(sel_way);
            o_res_data.line_tag    = r_job.tag;
            o_res_data.byte_offset = r_job.off;
            o_res_data.fill_block  = r_hit ? '0 : r_job.blk;
            o_res_data.evicted     = !r_hit && !r_inv_found;
        end
    end

    // Control registers and valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= sacl_pkg::ST_IDLE;
            r_cmp_vld <= 1'b0;
            r_valid   <= '0;
        end else begin
            r_state   <= n_state;
            r_cmp_vld <= rd_en;
            if (set_valid) begin
                r_valid[line_cmp] <= 1'b1;
            end
        end
    end

    // Item context, way walk and scan results
    always_ff @(posedge i_clk) begin
        if (o_job_pop) begin
            r_job       <= in_job;
            r_base      <= in_base;
            r_ways      <= in_ways;
            r_idx       <= '0;
            r_hit       <= 1'b0;
            r_inv_found <= 1'b0;
        end
        if (r_state == sacl_pkg::ST_SCAN || r_state == sacl_pkg::ST_UPDATE) begin
            r_cmp_idx <= r_idx[LINE_W-1:0];
            r_idx     <= issue ? r_idx + 1'b1 : '0;
        end
        if (r_state == sacl_pkg::ST_SCAN && r_cmp_vld) begin
            if (cmp_valid && cmp_tag == r_job.tag && !r_hit) begin
                r_hit     <= 1'b1;
                r_hit_way <= r_cmp_idx;
                r_hit_age <= cmp_age;
            end
            if (!cmp_valid && !r_inv_found) begin
                r_inv_found <= 1'b1;
                r_inv_way   <= r_cmp_idx;
            end
            if (cmp_valid && (r_cmp_idx == '0 || cmp_age > r_vic_age)) begin
                r_vic_way <= r_cmp_idx;
                r_vic_age <= cmp_age;
            end
        end
    end

    // Store read port
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rdata <= r_mem[line_rd];
        end
    end

    // Store write port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[line_cmp] <= wr_data;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/set_assoc_cache_lookup_lru_unit.sv -----
// The front classifies each address into a two-entry job queue, which takes new
//   addresses while a lookup is in progress until it fills; the back walks the W ways
//   of the set twice (W = TOTAL_LINES >> effective sets_log2), one tag/age read per
//   cycle, then waits for room in the result queue. Out-of-range addresses skip both walks.
// Reset: synchronous, active low; clears valid bits, queues and config to defaults.
`default_nettype none

module set_assoc_cache_lookup_lru_unit #(
    parameter int TOTAL_LINES  = 16,
    parameter int ADDRESS_BITS = 16
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_cfg_we,
    input  wire logic [sacl_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  wire logic [sacl_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    input  wire logic                                   push,
    output logic                                        full,
    input  wire logic [sacl_pkg::ADDR_IN_W-1:0]         i_address,
    output logic                                        empty,
    input  wire logic                                   pop,
    output logic                                        o_status,
    output logic                                        o_hit,
    output logic [sacl_pkg::SET_OUT_W-1:0]              o_set_index,
    output logic [sacl_pkg::WAY_OUT_W-1:0]              o_way,
    output logic [sacl_pkg::TAG_W-1:0]                  o_line_tag,
    output logic [sacl_pkg::OFF_W-1:0]                  o_byte_offset,
    output logic [sacl_pkg::BLK_W-1:0]                  o_fill_block,
    output logic                                        o_evicted
);

    localparam int JOB_W = $bits(sacl_pkg::t_job) + $clog2(TOTAL_LINES) +
                           $clog2(TOTAL_LINES + 1);
    localparam int RES_W = $bits(sacl_pkg::t_result);

    sacl_pkg::t_cfg    r_cfg;
    logic              job_push;
    logic [JOB_W-1:0]  job_wdata;
    logic              job_full;
    logic              job_pop;
    logic [JOB_W-1:0]  job_rdata;
    logic              job_empty;
    logic              res_push;
    sacl_pkg::t_result res_wdata;
    logic              res_full;
    logic [RES_W-1:0]  res_rdata;
    sacl_pkg::t_result res_head;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.block_bytes_log2  <= sacl_pkg::RST_BLOCK_LOG2;
            r_cfg.sets_log2         <= sacl_pkg::RST_SETS_LOG2;
            r_cfg.memory_bytes_log2 <= sacl_pkg::RST_MEM_LOG2;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                sacl_pkg::CFG_BLOCK_LOG2: r_cfg.block_bytes_log2  <= i_cfg_data[3:0];
                sacl_pkg::CFG_SETS_LOG2:  r_cfg.sets_log2         <= i_cfg_data[2:0];
                sacl_pkg::CFG_MEM_LOG2:   r_cfg.memory_bytes_log2 <= i_cfg_data;
                default: r_cfg <= r_cfg;
            endcase
        end
    end

    // Classify incoming addresses
    sacl_front #(
        .TOTAL_LINES  (TOTAL_LINES),
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_front (
        .i_cfg      (r_cfg),
        .i_push     (push),
        .i_address  (i_address),
        .o_full     (full),
        .o_job_push (job_push),
        .o_job_data (job_wdata),
        .i_job_full (job_full)
    );

    // Queue between front and back
    sacl_fifo #(
        .DATA_W (JOB_W),
        .DEPTH  (2)
    ) u_job_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_data  (job_wdata),
        .o_full  (job_full),
        .i_pop   (job_pop),
        .o_data  (job_rdata),
        .o_empty (job_empty)
    );

    // Lookup, replacement and LRU update
    sacl_back #(
        .TOTAL_LINES (TOTAL_LINES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_data  (job_rdata),
        .i_job_empty (job_empty),
        .o_job_pop   (job_pop),
        .o_res_push  (res_push),
        .o_res_data  (res_wdata),
        .i_res_full  (res_full)
    );

    // Result queue
    sacl_fifo #(
        .DATA_W (RES_W),
        .DEPTH  (2)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_wdata),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_rdata),
        .o_empty (empty)
    );

    assign res_head      = sacl_pkg::t_result'(res_rdata);
    assign o_status      = res_head.status;
    assign o_hit         = res_head.hit;
    assign o_set_index   = res_head.set_index;
    assign o_way         = res_head.way;
    assign o_line_tag    = res_head.line_tag;
    assign o_byte_offset = res_head.byte_offset;
    assign o_fill_block  = res_head.fill_block;
    assign o_evicted     = res_head.evicted;

endmodule

`default_nettype wire

// ----- rtl/core/sacl_check.sv -----
`default_nettype none

module sacl_check (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              full,
    input wire logic                              empty,
    input wire logic                              pop,
    input wire logic                              o_status,
    input wire logic                              o_hit,
    input wire logic                              o_evicted,
    input wire logic [sacl_pkg::BLK_W-1:0]        o_fill_block,
    input wire logic [sacl_pkg::TAG_W-1:0]        o_line_tag
);

    // Reset drains both queues
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("queues not cleared by reset");

    // Out-of-range items carry no lookup outcome
    a_oor_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_status |-> !o_hit && !o_evicted && o_fill_block == '0 &&
                               o_line_tag == '0)
        else $error("out-of-range result carries lookup fields");

    // A hit never loads or evicts
    a_hit_no_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_hit |-> !o_status && !o_evicted && o_fill_block == '0)
        else $error("hit reported with fill or eviction");

    // A waiting result holds until taken
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_line_tag) && $stable(o_hit))
        else $error("waiting result changed");

endmodule

bind set_assoc_cache_lookup_lru_unit sacl_check u_sacl_check (.*);

`default_nettype wire

// ----- bench/set_assoc_cache_lookup_lru_unit_tb.sv -----
`default_nettype none

module set_assoc_cache_lookup_lru_unit_tb;

    localparam int LINES       = 16;
    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_WAIT  = 2 * LINES + 8;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 150;

    typedef enum {ROW_WRITE, ROW_LOOKUP} t_row_kind;

    typedef struct {
        t_row_kind                          kind;
        logic [sacl_pkg::CFG_IDX_W-1:0]     reg_index;
        logic [sacl_pkg::ADDR_IN_W-1:0]     value;
        bit                                 typed;
        sacl_pkg::t_result                  want;
    } t_row;

    logic                               i_clk;
    logic                               i_rst_n;
    logic                               i_cfg_we;
    logic [sacl_pkg::CFG_IDX_W-1:0]     i_cfg_index;
    logic [sacl_pkg::CFG_DATA_W-1:0]    i_cfg_data;
    logic                               push;
    logic                               full;
    logic [sacl_pkg::ADDR_IN_W-1:0]     i_address;
    logic                               empty;
    logic                               pop;
    logic                               o_status;
    logic                               o_hit;
    logic [sacl_pkg::SET_OUT_W-1:0]     o_set_index;
    logic [sacl_pkg::WAY_OUT_W-1:0]     o_way;
    logic [sacl_pkg::TAG_W-1:0]         o_line_tag;
    logic [sacl_pkg::OFF_W-1:0]         o_byte_offset;
    logic [sacl_pkg::BLK_W-1:0]         o_fill_block;
    logic                               o_evicted;

    // Cache model state and configuration
    logic [3:0]                         cur_block_log2;
    logic [2:0]                         cur_sets_log2;
    logic [4:0]                         cur_mem_log2;
    logic                               line_ok [LINES];
    logic [sacl_pkg::TAG_W-1:0]         line_tags [LINES];
    logic [sacl_pkg::AGE_W-1:0]         lru_age [LINES];

    sacl_pkg::t_result                  expected_results[$];
    int                                 mismatch_count = 0;
    int                                 cycle_count = 0;

    // Address shaping for the random phases
    int unsigned                        shape_b;
    int unsigned                        shape_s;
    int unsigned                        shape_ways;
    int unsigned                        shape_mem;
    int unsigned                        shape_tag_base;

    set_assoc_cache_lookup_lru_unit #(
        .TOTAL_LINES (LINES),
        .ADDRESS_BITS(sacl_pkg::ADDR_IN_W)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .push         (push),
        .full         (full),
        .i_address    (i_address),
        .empty        (empty),
        .pop          (pop),
        .o_status     (o_status),
        .o_hit        (o_hit),
        .o_set_index  (o_set_index),
        .o_way        (o_way),
        .o_line_tag   (o_line_tag),
        .o_byte_offset(o_byte_offset),
        .o_fill_block (o_fill_block),
        .o_evicted    (o_evicted)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic sacl_pkg::t_result mk_result(logic st, logic h, logic [3:0] set_i,
                                                    logic [3:0] w, logic [15:0] tg,
                                                    logic [7:0] off, logic [15:0] fb,
                                                    logic ev);
        sacl_pkg::t_result r;
        r.status      = st;
        r.hit         = h;
        r.set_index   = set_i;
        r.way         = w;
        r.line_tag    = tg;
        r.byte_offset = off;
        r.fill_block  = fb;
        r.evicted     = ev;
        return r;
    endfunction

    function automatic t_row cfg_row(logic [sacl_pkg::CFG_IDX_W-1:0] idx,
                                     logic [sacl_pkg::CFG_DATA_W-1:0] data);
        t_row r;
        r.kind      = ROW_WRITE;
        r.reg_index = idx;
        r.value     = {11'd0, data};
        r.typed     = 1'b0;
        r.want      = '0;
        return r;
    endfunction

    function automatic t_row lookup_row(logic [sacl_pkg::ADDR_IN_W-1:0] addr);
        t_row r;
        r.kind      = ROW_LOOKUP;
        r.reg_index = '0;
        r.value     = addr;
        r.typed     = 1'b0;
        r.want      = '0;
        return r;
    endfunction

    function automatic t_row checked_row(logic [sacl_pkg::ADDR_IN_W-1:0] addr,
                                         sacl_pkg::t_result want);
        t_row r;
        r       = lookup_row(addr);
        r.typed = 1'b1;
        r.want  = want;
        return r;
    endfunction

    // Make way w newest; other valid ways younger than the limit grow older
    function automatic void touch_way(int unsigned base, int unsigned ways,
                                      int unsigned w, int unsigned age_limit);
        for (int unsigned j = 0; j < ways; j++) begin
            if (j != w && line_ok[base + j] && lru_age[base + j] < age_limit &&
                lru_age[base + j] < sacl_pkg::AGE_MAX) begin
                lru_age[base + j] = lru_age[base + j] + 1'b1;
            end
        end
        lru_age[base + w] = '0;
    endfunction

    // Look up one address in the cache model and update tags and ages
    function automatic sacl_pkg::t_result predict_lookup(logic [sacl_pkg::ADDR_IN_W-1:0] addr);
        sacl_pkg::t_result r;
        int unsigned b;
        int unsigned s;
        int unsigned ways;
        int unsigned set_sel;
        int unsigned base;
        int unsigned w;
        logic [15:0] blk;
        logic [15:0] tg;
        logic [15:0] off;
        bit          hit;
        bit          free_way;
        r = '0;
        if (64'(addr) >= (64'd1 << cur_mem_log2)) begin
            r.status = 1'b1;
            return r;
        end
        b = (cur_block_log2 > 4'd8) ? 32'd8 : 32'(cur_block_log2);
        s = 32'(cur_sets_log2);
        while (s > 0 && (1 << s) > LINES) s--;
        ways    = LINES >> s;
        off     = addr & ((16'd1 << b) - 16'd1);
        blk     = addr >> b;
        set_sel = 32'(blk & ((16'd1 << s) - 16'd1));
        tg      = blk >> s;
        base    = set_sel * ways;
        hit     = 1'b0;
        w       = 0;
        for (int unsigned j = 0; j < ways; j++) begin
            if (!hit && line_ok[base + j] && line_tags[base + j] == tg) begin
                hit = 1'b1;
                w   = j;
            end
        end
        if (hit) begin
            touch_way(base, ways, w, 32'(lru_age[base + w]));
        end else begin
            free_way = 1'b0;
            for (int unsigned j = 0; j < ways; j++) begin
                if (!free_way && !line_ok[base + j]) begin
                    free_way = 1'b1;
                    w        = j;
                end
            end
            if (!free_way) begin
                w = 0;
                for (int unsigned j = 1; j < ways; j++) begin
                    if (lru_age[base + j] > lru_age[base + w]) w = j;
                end
                r.evicted = 1'b1;
            end
            line_ok[base + w]   = 1'b1;
            line_tags[base + w] = tg;
            touch_way(base, ways, w, 32'(sacl_pkg::AGE_MAX) + 32'd1);
            r.fill_block = blk;
        end
        r.hit         = hit;
        r.set_index   = set_sel[3:0];
        r.way         = w[3:0];
        r.line_tag    = tg;
        r.byte_offset = off[7:0];
        return r;
    endfunction

    // Mostly reuse a small pool of tags per set so hits and evictions both occur
    function automatic logic [sacl_pkg::ADDR_IN_W-1:0] pick_address();
        int unsigned a;
        int unsigned span;
        int unsigned sel;
        span = (shape_mem >= 16) ? 32'h10000 : (32'd1 << shape_mem);
        sel  = $urandom_range(0, 99);
        if (sel < 65) begin
            a = ((shape_tag_base + $urandom_range(0, shape_ways + 1)) << (shape_b + shape_s)) |
                ($urandom_range(0, (1 << shape_s) - 1) << shape_b) |
                $urandom_range(0, (1 << shape_b) - 1);
            a = (a & 32'hFFFF) % span;
        end else if (sel < 80) begin
            a = $urandom_range(0, span - 1);
        end else if (sel < 90 && span < 32'h10000) begin
            a = $urandom_range(span, 32'hFFFF);
        end else begin
            a = $urandom_range(0, 32'hFFFF);
        end
        return a[15:0];
    endfunction

    // Offer one item and hold it until the cache takes it
    task automatic send_lookup(logic [sacl_pkg::ADDR_IN_W-1:0] addr, bit typed,
                               sacl_pkg::t_result want);
        sacl_pkg::t_result predicted;
        @(negedge i_clk);
        push      <= 1'b1;
        i_address <= addr;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        predicted = predict_lookup(addr);
        expected_results.push_back(typed ? want : predicted);
    endtask

    // Drop push, with junk on the address lines
    task automatic hold_off(int n);
        repeat (n) begin
            @(negedge i_clk);
            push      <= 1'b0;
            i_address <= 16'($urandom);
        end
    endtask

    // Wait until the cache is idle, then write one register
    task automatic write_reg(logic [sacl_pkg::CFG_IDX_W-1:0] idx,
                             logic [sacl_pkg::CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        push <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        case (idx)
            sacl_pkg::CFG_BLOCK_LOG2: cur_block_log2 = data[3:0];
            sacl_pkg::CFG_SETS_LOG2:  cur_sets_log2  = data[2:0];
            sacl_pkg::CFG_MEM_LOG2:   cur_mem_log2   = data[4:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Compare each popped result with the oldest expectation
    always @(posedge i_clk) begin : check_results
        sacl_pkg::t_result got;
        sacl_pkg::t_result want;
        if (i_rst_n && pop && !empty) begin
            got = mk_result(o_status, o_hit, o_set_index, o_way, o_line_tag,
                            o_byte_offset, o_fill_block, o_evicted);
            if (expected_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) $display("unexpected result %p", got);
            end else begin
                want = expected_results.pop_front();
                if (got.status !== want.status || got.hit !== want.hit ||
                    got.set_index !== want.set_index || got.way !== want.way ||
                    got.line_tag !== want.line_tag || got.byte_offset !== want.byte_offset ||
                    got.fill_block !== want.fill_block || got.evicted !== want.evicted) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("result mismatch: expected %p", want);
                        $display("                 actual   %p", got);
                    end
                end
            end
        end
    end

    // Stall the result side in runs of changing pressure
    initial begin : drain_results
        int mode;
        int run;
        pop = 1'b0;
        forever begin
            mode = $urandom_range(0, 3);
            run  = $urandom_range(16, 96);
            repeat (run) begin
                @(negedge i_clk);
                case (mode)
                    0:       pop <= 1'b1;
                    1:       pop <= 1'($urandom_range(0, 1));
                    2:       pop <= ($urandom_range(0, 7) == 0);
                    default: pop <= ($urandom_range(0, 15) != 0);
                endcase
            end
        end
    end

    initial begin : stimulus
        t_row        directed_rows[$];
        int unsigned pb;
        int unsigned ps;
        int unsigned pm;
        int          items_left;
        int          burst;
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = '0;
        i_cfg_data     = '0;
        push           = 1'b0;
        i_address      = '0;
        cur_block_log2 = sacl_pkg::RST_BLOCK_LOG2;
        cur_sets_log2  = sacl_pkg::RST_SETS_LOG2;
        cur_mem_log2   = sacl_pkg::RST_MEM_LOG2;
        for (int i = 0; i < LINES; i++) begin
            line_ok[i]   = 1'b0;
            line_tags[i] = '0;
            lru_age[i]   = '0;
        end

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset geometry, set fill and eviction, range check, extreme geometries
        directed_rows = {
            checked_row(16'h0000, mk_result(1'b0, 1'b0, 4'd0, 4'd0, 16'h0000, 8'd0,
                                            16'h0000, 1'b0)),
            checked_row(16'h0003, mk_result(1'b0, 1'b1, 4'd0, 4'd0, 16'h0000, 8'd3,
                                            16'h0000, 1'b0)),
            checked_row(16'hFFFF, mk_result(1'b0, 1'b0, 4'd3, 4'd0, 16'h0FFF, 8'd3,
                                            16'h3FFF, 1'b0)),
            lookup_row(16'h0010),
            lookup_row(16'h0020),
            lookup_row(16'h0030),
            lookup_row(16'h0040),
            lookup_row(16'h0013),
            lookup_row(16'h0004),
            cfg_row(sacl_pkg::CFG_MEM_LOG2, 5'd4),
            checked_row(16'h0010, mk_result(1'b1, 1'b0, 4'd0, 4'd0, 16'h0000, 8'd0,
                                            16'h0000, 1'b0)),
            checked_row(16'hFFFF, mk_result(1'b1, 1'b0, 4'd0, 4'd0, 16'h0000, 8'd0,
                                            16'h0000, 1'b0)),
            lookup_row(16'h000F),
            cfg_row(sacl_pkg::CFG_BLOCK_LOG2, 5'd15),
            cfg_row(sacl_pkg::CFG_SETS_LOG2, 5'd7),
            cfg_row(sacl_pkg::CFG_MEM_LOG2, 5'd31),
            lookup_row(16'hFFFF),
            lookup_row(16'h0100),
            cfg_row(sacl_pkg::CFG_BLOCK_LOG2, 5'd0),
            cfg_row(sacl_pkg::CFG_SETS_LOG2, 5'd0),
            cfg_row(sacl_pkg::CFG_MEM_LOG2, 5'd0),
            lookup_row(16'h0000),
            checked_row(16'h0001, mk_result(1'b1, 1'b0, 4'd0, 4'd0, 16'h0000, 8'd0,
                                            16'h0000, 1'b0)),
            cfg_row(sacl_pkg::CFG_MEM_LOG2, 5'd16),
            lookup_row(16'h8000),
            lookup_row(16'h8000),
            lookup_row(16'h7FFF)
        };
        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_WRITE) begin
                write_reg(directed_rows[i].reg_index, directed_rows[i].value[4:0]);
            end else begin
                send_lookup(directed_rows[i].value, directed_rows[i].typed,
                            directed_rows[i].want);
            end
        end

        // Random phases, each under a fresh geometry written while idle
        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: begin pb = 0;  ps = 0; pm = 16; end
                1: begin pb = 8;  ps = 4; pm = 16; end
                2: begin pb = 15; ps = 7; pm = 31; end
                3: begin pb = 1;  ps = 3; pm = 9;  end
                4: begin pb = 3;  ps = 1; pm = 1;  end
                default: begin
                    pb = $urandom_range(0, 15);
                    ps = $urandom_range(0, 7);
                    pm = $urandom_range(6, 20);
                end
            endcase
            write_reg(sacl_pkg::CFG_BLOCK_LOG2, pb[4:0]);
            write_reg(sacl_pkg::CFG_SETS_LOG2, ps[4:0]);
            write_reg(sacl_pkg::CFG_MEM_LOG2, pm[4:0]);
            shape_b        = (pb > 8) ? 8 : pb;
            shape_s        = (ps > 4) ? 4 : ps;
            shape_ways     = LINES >> shape_s;
            shape_mem      = pm;
            shape_tag_base = $urandom_range(0, 15);

            items_left = PHASE_ITEMS;
            while (items_left > 0) begin
                burst = $urandom_range(1, 24);
                while (burst > 0 && items_left > 0) begin
                    send_lookup(pick_address(), 1'b0, '0);
                    burst--;
                    items_left--;
                end
                hold_off(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
            end
        end

        // Drain, then give stray results time to show up
        hold_off(1);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

`default_nettype wire
